// ----- src/swsm_pkg.sv -----
// sliding window slope meter: shared types and constants
// no dependencies; used by sliding_window_slope_meter and the testbench
`timescale 1ns / 1ps

package swsm_pkg;

   // default sizing
   localparam int WINDOW_MAX_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // csr port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 15;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WINDOW_LENGTH,
      CSR_SATURATION_SLOPE,
      CSR_ACCEL_THRESHOLD,
      CSR_EVENT_ENABLE
   } csr_index_type;

   // register reset values
   localparam logic [6:0]  WINDOW_RST = 7'd16;
   localparam logic [14:0] SAT_RST    = 15'd256;
   localparam logic [14:0] THR_RST    = 15'd256;

   // output limits
   localparam logic [14:0] SLOPE_MAX = 15'd32767;
   localparam logic [14:0] SCORE_ONE = 15'd16384;
   localparam int          SCORE_FRAC = 14;

   // result word layout
   localparam int RSP_BITS   = 66;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_NUM_A,
      ST_NUM_B,
      ST_DEN_A,
      ST_DEN_B,
      ST_THR,
      ST_ACC,
      ST_DIV_Q,
      ST_SCORE,
      ST_DIV_S,
      ST_DONE
   } state_type;

endpackage

// ----- src/sliding_window_slope_meter.sv -----
// least-squares slope over a window of recent samples, with score and trend event
// depends on swsm_pkg; ring memory, one shared multiplier and one shared divider
// each word walks the n held samples in the ring (n >= 2; skipped below two samples),
// then runs two bit-serial divisions of DVD_W bits (DVD_W = 39 by default)
// a new word is taken only in idle, once the previous result has been loaded for output
// reset: synchronous, empties the history (fill count, write pointer) and sets counters and registers to defaults
`timescale 1ns / 1ps

module sliding_window_slope_meter #(
   parameter int WINDOW_MAX  = swsm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = swsm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [SAMPLE_BITS-1:0] sample_in, rest zero
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] slope_value, [31:16] trend_score, [32] accel_flag,
   // [33] trend_event, [65:34] sample_count, rest zero
   output logic [swsm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [swsm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [swsm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SX_W   = 2 * CNT_W;
   localparam int SX2_W  = 3 * CNT_W;
   localparam int SY_W   = SAMPLE_BITS + CNT_W;
   localparam int SXY_W  = SAMPLE_BITS + 2 * CNT_W;
   localparam int NUM_W  = SAMPLE_BITS + 3 * CNT_W + 1;
   localparam int DEN_W  = 4 * CNT_W;
   localparam int MA_W   = (SX_W + 1 > 16) ? SX_W + 1 : 16;
   localparam int MB_A   = (SXY_W > DEN_W + 1) ? SXY_W : DEN_W + 1;
   localparam int MB_W   = (MB_A > SX2_W + 1) ? MB_A : SX2_W + 1;
   localparam int PROD_W = MA_W + MB_W;
   localparam int DVD_A  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int DVD_W  = ((DVD_A > 30) ? DVD_A : 30) + 1;
   localparam int DVS_W  = (DEN_W > 15) ? DEN_W : 15;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   // state and configuration
   swsm_pkg::state_type state_ff, state_in;
   logic [6:0]          win_len_ff;
   logic [14:0]         sat_ff;
   logic [14:0]         thr_ff;
   logic                evt_en_ff;
   logic [PTR_W-1:0]    wp_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic                prev_ff;
   logic [31:0]         total_ff;
   logic                rsp_valid_ff;

   // datapath
   logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [CNT_W-1:0]        k_ff;
   logic signed [SY_W-1:0]  sy_ff;
   logic signed [SXY_W-1:0] sxy_ff;
   logic [SX_W-1:0]         sx_ff;
   logic [SX2_W-1:0]        sx2_ff;
   logic [SX2_W-1:0]        sq_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [NUM_W-1:0]        anum_ff;
   logic                    neg_ff;
   logic                    accel_ff;
   logic [DVD_W-1:0]        quo_ff;
   logic [DVS_W-1:0]        rem_ff;
   logic [DVS_W-1:0]        dvs_ff;
   logic [DCNT_W-1:0]       cnt_ff;
   logic [14:0]             q_ff;
   logic [swsm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // combinational
   logic                    req_accept;
   logic                    load_rsp;
   logic [CNT_W-1:0]        w_eff;
   logic [CNT_W-1:0]        wp_plus;
   logic [PTR_W-1:0]        wp_next;
   logic [CNT_W:0]          start_sum;
   logic [PTR_W-1:0]        start_ptr;
   logic [CNT_W-1:0]        rd_plus;
   logic [PTR_W-1:0]        rd_next;
   logic [CNT_W-1:0]        idx;
   logic signed [CNT_W+SAMPLE_BITS:0] iy;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] mul_out;
   logic [NUM_W-1:0]        num_abs;
   logic [14:0]             sat_eff;
   logic [14:0]             q_sat;
   logic [14:0]             s_sat;
   logic [DVS_W:0]          trial;
   logic                    trial_ge;
   logic signed [15:0]      slope_val;
   logic signed [15:0]      score_val;
   logic                    event_val;

   // effective window, clamped to 2..WINDOW_MAX
   always_comb begin
      if (win_len_ff < 7'd2) begin
         w_eff = CNT_W'(2);
      end else if (int'(win_len_ff) > WINDOW_MAX) begin
         w_eff = CNT_W'(WINDOW_MAX);
      end else begin
         w_eff = CNT_W'(win_len_ff);
      end
   end

   // ring pointer arithmetic
   always_comb begin
      wp_plus   = CNT_W'(wp_ff) + CNT_W'(1);
      wp_next   = (wp_plus == w_eff) ? '0 : wp_plus[PTR_W-1:0];
      start_sum = (CNT_W+1)'(wp_ff) + (CNT_W+1)'(w_eff) - (CNT_W+1)'(fill_ff);
      start_ptr = (start_sum >= (CNT_W+1)'(w_eff)) ?
                  PTR_W'(start_sum - (CNT_W+1)'(w_eff)) : PTR_W'(start_sum);
      rd_plus   = CNT_W'(rd_ptr_ff) + CNT_W'(1);
      rd_next   = (rd_plus == w_eff) ? '0 : rd_plus[PTR_W-1:0];
      idx       = k_ff - CNT_W'(1);
      iy        = $signed({1'b0, idx}) * rd_data_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swsm_pkg::ST_IDLE:  if (req_accept) state_in = swsm_pkg::ST_SETUP;
         swsm_pkg::ST_SETUP: begin
            state_in = (fill_ff < CNT_W'(2)) ? swsm_pkg::ST_THR : swsm_pkg::ST_WALK;
         end
         swsm_pkg::ST_WALK:  if (k_ff == fill_ff) state_in = swsm_pkg::ST_NUM_A;
         swsm_pkg::ST_NUM_A: state_in = swsm_pkg::ST_NUM_B;
         swsm_pkg::ST_NUM_B: state_in = swsm_pkg::ST_DEN_A;
         swsm_pkg::ST_DEN_A: state_in = swsm_pkg::ST_DEN_B;
         swsm_pkg::ST_DEN_B: state_in = swsm_pkg::ST_THR;
         swsm_pkg::ST_THR:   state_in = swsm_pkg::ST_ACC;
         swsm_pkg::ST_ACC:   state_in = swsm_pkg::ST_DIV_Q;
         swsm_pkg::ST_DIV_Q: if (cnt_ff == DCNT_W'(1)) state_in = swsm_pkg::ST_SCORE;
         swsm_pkg::ST_SCORE: state_in = swsm_pkg::ST_DIV_S;
         swsm_pkg::ST_DIV_S: if (cnt_ff == DCNT_W'(1)) state_in = swsm_pkg::ST_DONE;
         swsm_pkg::ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = swsm_pkg::ST_IDLE;
         default:            state_in = swsm_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and shared multiplier operands
   always_comb begin
      req_tready = (state_ff == swsm_pkg::ST_IDLE);
      load_rsp   = (state_ff == swsm_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         swsm_pkg::ST_NUM_A: begin
            mul_a = MA_W'($signed({1'b0, fill_ff}));
            mul_b = MB_W'(sxy_ff);
         end
         swsm_pkg::ST_NUM_B: begin
            mul_a = MA_W'($signed({1'b0, sx_ff}));
            mul_b = MB_W'(sy_ff);
         end
         swsm_pkg::ST_DEN_A: begin
            mul_a = MA_W'($signed({1'b0, fill_ff}));
            mul_b = MB_W'($signed({1'b0, sx2_ff}));
         end
         swsm_pkg::ST_DEN_B: begin
            mul_a = MA_W'($signed({1'b0, sx_ff}));
            mul_b = MB_W'($signed({1'b0, sx_ff}));
         end
         swsm_pkg::ST_THR: begin
            mul_a = MA_W'($signed({1'b0, thr_ff}));
            mul_b = MB_W'($signed({1'b0, den_ff}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;
   assign mul_out    = mul_a * mul_b;

   // shared divider step and result shaping
   always_comb begin
      num_abs   = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
      sat_eff   = (sat_ff == '0) ? 15'd1 : sat_ff;
      trial     = {rem_ff, quo_ff[DVD_W-1]};
      trial_ge  = trial >= {1'b0, dvs_ff};
      q_sat     = (quo_ff > DVD_W'(swsm_pkg::SLOPE_MAX)) ? swsm_pkg::SLOPE_MAX : quo_ff[14:0];
      s_sat     = (quo_ff > DVD_W'(swsm_pkg::SCORE_ONE)) ? swsm_pkg::SCORE_ONE : quo_ff[14:0];
      slope_val = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      score_val = neg_ff ? -$signed({1'b0, s_sat}) : $signed({1'b0, s_sat});
      event_val = accel_ff && !prev_ff && evt_en_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swsm_pkg::ST_IDLE;
         win_len_ff   <= swsm_pkg::WINDOW_RST;
         sat_ff       <= swsm_pkg::SAT_RST;
         thr_ff       <= swsm_pkg::THR_RST;
         evt_en_ff    <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         prev_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               swsm_pkg::CSR_WINDOW_LENGTH: begin
                  win_len_ff <= csr_wdata[6:0];
                  wp_ff      <= '0;
                  fill_ff    <= '0;
                  prev_ff    <= 1'b0;
               end
               swsm_pkg::CSR_SATURATION_SLOPE: sat_ff    <= csr_wdata;
               swsm_pkg::CSR_ACCEL_THRESHOLD:  thr_ff    <= csr_wdata;
               swsm_pkg::CSR_EVENT_ENABLE:     evt_en_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_accept) begin
            wp_ff    <= wp_next;
            total_ff <= total_ff + 32'd1;
            if (fill_ff < w_eff) fill_ff <= fill_ff + CNT_W'(1);
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            prev_ff      <= accel_ff;
         end
      end
   end

   // sample ring, registered read
   always_ff @(posedge clock) begin
      if (req_accept) ring_mem[wp_ff] <= req_tdata[SAMPLE_BITS-1:0];
      rd_data_ff <= ring_mem[rd_ptr_ff];
   end

   // sums, products and divisions
   always_ff @(posedge clock) begin
      case (state_ff)
         swsm_pkg::ST_SETUP: begin
            rd_ptr_ff <= start_ptr;
            k_ff      <= '0;
            sy_ff     <= '0;
            sxy_ff    <= '0;
            sx_ff     <= '0;
            sx2_ff    <= '0;
            sq_ff     <= '0;
            num_ff    <= '0;
            den_ff    <= DEN_W'(1);
         end
         swsm_pkg::ST_WALK: begin
            if (k_ff < fill_ff) rd_ptr_ff <= rd_next;
            k_ff <= k_ff + CNT_W'(1);
            // fold in the sample read last cycle, x = k-1
            if (k_ff != '0) begin
               sy_ff  <= sy_ff + SY_W'(rd_data_ff);
               sxy_ff <= sxy_ff + SXY_W'(iy);
               sx_ff  <= sx_ff + SX_W'(idx);
               sx2_ff <= sx2_ff + sq_ff;
               sq_ff  <= sq_ff + SX2_W'({idx, 1'b1});
            end
         end
         swsm_pkg::ST_NUM_A: prod_ff <= mul_out;
         swsm_pkg::ST_NUM_B: num_ff  <= NUM_W'(prod_ff - mul_out);
         swsm_pkg::ST_DEN_A: prod_ff <= mul_out;
         swsm_pkg::ST_DEN_B: den_ff  <= DEN_W'(prod_ff - mul_out);
         swsm_pkg::ST_THR: begin
            prod_ff <= mul_out;
            anum_ff <= num_abs;
            neg_ff  <= num_ff[NUM_W-1];
         end
         swsm_pkg::ST_ACC: begin
            accel_ff <= PROD_W'(anum_ff) >= PROD_W'($unsigned(prod_ff));
            // rounded slope: (|num| + den/2) / den
            quo_ff   <= DVD_W'(anum_ff) + DVD_W'(den_ff >> 1);
            dvs_ff   <= DVS_W'(den_ff);
            rem_ff   <= '0;
            cnt_ff   <= DCNT_W'(DVD_W);
         end
         swsm_pkg::ST_DIV_Q, swsm_pkg::ST_DIV_S: begin
            rem_ff <= trial_ge ? DVS_W'(trial - {1'b0, dvs_ff}) : DVS_W'(trial);
            quo_ff <= {quo_ff[DVD_W-2:0], trial_ge};
            cnt_ff <= cnt_ff - DCNT_W'(1);
         end
         swsm_pkg::ST_SCORE: begin
            q_ff   <= q_sat;
            // rounded score: (q * 2^14 + sat/2) / sat
            quo_ff <= DVD_W'({q_sat, {swsm_pkg::SCORE_FRAC{1'b0}}}) + DVD_W'(sat_eff >> 1);
            dvs_ff <= DVS_W'(sat_eff);
            rem_ff <= '0;
            cnt_ff <= DCNT_W'(DVD_W);
         end
         default: ;
      endcase
      if (load_rsp) begin
         rsp_data_ff <= swsm_pkg::RSP_DATA_W'({total_ff, event_val, accel_ff,
                                               score_val, slope_val});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("block ready right after taking a word");

   a_fill_in_window: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= w_eff)
      else $error("fill count beyond window");

   a_wp_in_window: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(wp_ff) < w_eff)
      else $error("write pointer beyond window");

   a_zero_slope_zero_score: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:0] == 16'd0) |-> (rsp_tdata[31:16] == 16'd0))
      else $error("nonzero score with zero slope");

endmodule

// ----- tb/testbench.sv -----
// testbench for sliding_window_slope_meter: directed table, corner settings, then random samples
// depends on swsm_pkg and the block; self-checking against a built-in slope predictor
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [31:0] sample_count;
      logic        trend_event;
      logic        accel_flag;
      logic [15:0] trend_score;
      logic [15:0] slope_value;
   } slope_result_type;

   // directed row: sample plus optional typed-in expectation
   typedef struct {
      logic [15:0] sample;
      bit          fixed;
      logic [15:0] slope;
      logic [15:0] score;
      bit          accel;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [swsm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic        csr_we;
   logic [swsm_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [swsm_pkg::CSR_DATA_W-1:0] csr_wdata;

   sliding_window_slope_meter i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // predictor copy of registers and history
   logic [6:0]  win_reg;
   logic [14:0] sat_reg;
   logic [14:0] thr_reg;
   logic        evt_reg;
   logic signed [15:0] hist [swsm_pkg::WINDOW_MAX_DEF];
   int unsigned wr_ptr;
   int unsigned held;
   bit          last_accel;
   logic [31:0] total_words;

   slope_result_type expected_slopes[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          recv_hold;
   int          errors;
   int          stall_cycles;
   int          words_sent;
   int          words_checked;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_history();
      for (int i = 0; i < swsm_pkg::WINDOW_MAX_DEF; i++) hist[i] = '0;
      wr_ptr = 0;
      held = 0;
      last_accel = 1'b0;
   endfunction

   function automatic void model_write(swsm_pkg::csr_index_type idx, logic [14:0] val);
      case (idx)
         swsm_pkg::CSR_WINDOW_LENGTH: begin
            win_reg = val[6:0];
            clear_history();
         end
         swsm_pkg::CSR_SATURATION_SLOPE: sat_reg = val;
         swsm_pkg::CSR_ACCEL_THRESHOLD:  thr_reg = val;
         swsm_pkg::CSR_EVENT_ENABLE:     evt_reg = val[0];
         default: ;
      endcase
   endfunction

   // least-squares slope of the held window after taking one sample
   function automatic slope_result_type predict_slope(logic signed [15:0] s);
      slope_result_type r;
      int unsigned w, n, start;
      longint sx, sy, sxy, sx2, num, den, y;
      longint unsigned anum, q, sat, sc;
      bit accel;
      w = win_reg < 2 ? 2 : (win_reg > swsm_pkg::WINDOW_MAX_DEF ?
                             swsm_pkg::WINDOW_MAX_DEF : win_reg);
      total_words = total_words + 1;
      if (wr_ptr >= w) wr_ptr = 0;
      if (held > w) held = w;
      hist[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % w;
      if (held < w) held++;
      n = held;
      num = 0;
      den = 1;
      if (n >= 2) begin
         sx = 0; sy = 0; sxy = 0; sx2 = 0;
         start = (wr_ptr + w - n) % w;
         for (int i = 0; i < n; i++) begin
            y = hist[(start + i) % w];
            sx += i;
            sy += y;
            sxy += i * y;
            sx2 += i * i;
         end
         num = n * sxy - sx * sy;
         den = n * sx2 - sx * sx;
         if (den <= 0) begin
            num = 0;
            den = 1;
         end
      end
      anum = num < 0 ? -num : num;
      q = (anum + den / 2) / den;
      if (q > 32767) q = 32767;
      sat = sat_reg == 0 ? 1 : sat_reg;
      sc = (q * 16384 + sat / 2) / sat;
      if (sc > 16384) sc = 16384;
      accel = anum >= longint'(thr_reg) * den;
      r.slope_value = num < 0 ? -q[15:0] : q[15:0];
      r.trend_score = num < 0 ? -sc[15:0] : sc[15:0];
      r.accel_flag = accel;
      r.trend_event = accel && !last_accel && evt_reg;
      r.sample_count = total_words;
      last_accel = accel;
      return r;
   endfunction

   task automatic write_reg(swsm_pkg::csr_index_type idx, logic [14:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      model_write(idx, val);
      @(posedge clock);
   endtask

   // offer one word, idling at random first
   task automatic send_sample(logic [15:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_slopes.push_back(predict_slope(s));
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_slopes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // biased random sample: extremes, ramps' neighbors and noise
   function automatic logic [15:0] rand_sample(int k);
      case ($urandom_range(4))
         0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         1: return 16'(k * 37);
         2: return 16'($signed(16'($urandom_range(255))) - 128);
         default: return 16'($urandom());
      endcase
   endfunction

   // receiver side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      slope_result_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[65:0];
         if (expected_slopes.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            errors++;
         end else begin
            exp_r = expected_slopes.pop_front();
            words_checked++;
            if (got.slope_value !== exp_r.slope_value) begin
               $error("slope_value exp %0d got %0d", $signed(exp_r.slope_value),
                      $signed(got.slope_value));
               errors++;
            end
            if (got.trend_score !== exp_r.trend_score) begin
               $error("trend_score exp %0d got %0d", $signed(exp_r.trend_score),
                      $signed(got.trend_score));
               errors++;
            end
            if (got.accel_flag !== exp_r.accel_flag) begin
               $error("accel_flag exp %0b got %0b", exp_r.accel_flag,
                      got.accel_flag);
               errors++;
            end
            if (got.trend_event !== exp_r.trend_event) begin
               $error("trend_event exp %0b got %0b", exp_r.trend_event, got.trend_event);
               errors++;
            end
            if (got.sample_count !== exp_r.sample_count) begin
               $error("sample_count exp %0d got %0d", exp_r.sample_count, got.sample_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || recv_hold)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // long receiver hold-off while the sender keeps offering
   task automatic hold_receiver(int cycles);
      recv_hold = 1'b1;
      repeat (cycles) @(posedge clock);
      recv_hold = 1'b0;
   endtask

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      slope_result_type exp_r;
      logic [14:0] wins[5];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      recv_hold = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      win_reg = swsm_pkg::WINDOW_RST;
      sat_reg = swsm_pkg::SAT_RST;
      thr_reg = swsm_pkg::THR_RST;
      evt_reg = 1'b0;
      total_words = '0;
      clear_history();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first sample gives zero slope; a ramp of +1.0 gives exact +256
      write_reg(swsm_pkg::CSR_EVENT_ENABLE, 15'd1);
      rows.push_back('{16'h0100, 1'b1, 16'd0, 16'd0, 1'b0});
      rows.push_back('{16'h0200, 1'b1, 16'd256, 16'd16384, 1'b1});
      rows.push_back('{16'h0300, 1'b1, 16'd256, 16'd16384, 1'b1});
      rows.push_back('{16'h0000, 1'b0, '0, '0, 1'b0});
      rows.push_back('{16'h7fff, 1'b0, '0, '0, 1'b0});
      rows.push_back('{16'h8000, 1'b0, '0, '0, 1'b0});
      rows.push_back('{16'h7fff, 1'b0, '0, '0, 1'b0});
      rows.push_back('{16'h8000, 1'b0, '0, '0, 1'b0});
      rows.push_back('{16'hffff, 1'b0, '0, '0, 1'b0});
      rows.push_back('{16'h5555, 1'b0, '0, '0, 1'b0});
      rows.push_back('{16'haaaa, 1'b0, '0, '0, 1'b0});
      // walk the table on a fresh history
      write_reg(swsm_pkg::CSR_WINDOW_LENGTH, 15'd16);
      foreach (rows[i]) begin
         row = rows[i];
         send_sample(row.sample);
         // typed rows: the block is held to the values written in the table
         if (row.fixed) begin
            exp_r = expected_slopes[expected_slopes.size() - 1];
            exp_r.slope_value = row.slope;
            exp_r.trend_score = row.score;
            exp_r.accel_flag = row.accel;
            expected_slopes[expected_slopes.size() - 1] = exp_r;
         end
      end
      drain();

      // corner settings: window 2, window above max and zero, zero threshold/saturation
      write_reg(swsm_pkg::CSR_WINDOW_LENGTH, 15'd2);
      write_reg(swsm_pkg::CSR_SATURATION_SLOPE, 15'd0);
      write_reg(swsm_pkg::CSR_ACCEL_THRESHOLD, 15'd0);
      write_reg(swsm_pkg::CSR_EVENT_ENABLE, 15'd0);
      for (int k = 0; k < 4; k++) send_sample(rand_sample(k));
      drain();
      write_reg(swsm_pkg::CSR_WINDOW_LENGTH, 15'd127);
      write_reg(swsm_pkg::CSR_SATURATION_SLOPE, 15'd32767);
      write_reg(swsm_pkg::CSR_ACCEL_THRESHOLD, 15'd32767);
      for (int k = 0; k < 4; k++) send_sample(k[0] ? 16'h7fff : 16'h8000);
      drain();
      write_reg(swsm_pkg::CSR_WINDOW_LENGTH, 15'd0);
      for (int k = 0; k < 3; k++) send_sample(rand_sample(k));
      drain();

      // random phases across settings and idling patterns
      wins = '{15'd2, 15'd5, 15'd16, 15'd64, 15'd33};
      for (int ph = 0; ph < 9; ph++) begin
         send_idle_pct = ph < 3 ? 30 : (ph < 6 ? 64 : 0);
         recv_idle_pct = ph < 3 ? 64 : (ph < 6 ? 30 : 0);
         write_reg(swsm_pkg::CSR_WINDOW_LENGTH, wins[ph % 5]);
         write_reg(swsm_pkg::CSR_SATURATION_SLOPE,
                   ph == 4 ? 15'd1 : 15'($urandom_range(1, 2048)));
         write_reg(swsm_pkg::CSR_ACCEL_THRESHOLD,
                   ph == 7 ? 15'd0 : 15'($urandom_range(0, 600)));
         write_reg(swsm_pkg::CSR_EVENT_ENABLE, 15'(ph % 3 != 2));
         if (ph == 8) begin
            fork
               hold_receiver(3000);
               for (int k = 0; k < 20; k++) send_sample(rand_sample(k));
            join
         end
         for (int k = 0; k < 95; k++) send_sample(rand_sample(k));
         drain();
      end

      if (stall_cycles > 20000) @(posedge clock);
      $display("covered %0d samples, %0d results checked, windows 2..64 and clamped",
               words_sent, words_checked);
      $display("zero saturation/threshold, events on and off, long receiver hold-off");
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/swsm_pkg.sv
src/sliding_window_slope_meter.sv
tb/testbench.sv
